>>> hw/rtl/peqc_pkg.sv
// Shared types and constants for the per-input event quota counter.
// Has no dependencies; every other RTL file imports it.
`default_nettype none

package peqc_pkg;

  localparam int NUM_INPUTS_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;
  localparam int GROUP           = 4;

  typedef enum logic [1:0] {
    ACT_EVENT = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_REQUESTED = 2'd0,
    REG_MASK      = 2'd1,
    REG_LIVE      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] nonempty_inputs;
    logic [3:0]  query_index;
  } in_t;

  typedef struct packed {
    logic        is_needed;
    logic [31:0] needed_total;
    logic [31:0] queried_count;
    logic [31:0] queried_read_count;
    logic [31:0] lowest_count;
    logic        all_excluded;
  } out_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic needed;
  } lane_ctl_t;

  typedef struct packed {
    logic       valid;
    logic       needed;
    logic [3:0] query;
  } pend_t;

endpackage

`default_nettype wire

>>> hw/rtl/peqc_lane.sv
// One input's lane: accepted and read counters and the quota compare.
// Depends on peqc_pkg.
`default_nettype none

module peqc_lane
  import peqc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lane_ctl_t              ctl,
  input  wire logic                   sel,
  input  wire logic [31:0]            quota,
  output logic      [COUNT_WIDTH-1:0] count,
  output logic      [COUNT_WIDTH-1:0] read_count,
  output logic                        below
);

  localparam int CmpW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] read_count_next;

  assign below = sel && (CmpW'(count) < CmpW'(quota));

  always_comb begin
    count_next      = count;
    read_count_next = read_count;
    if (ctl.clear) begin
      count_next      = '0;
      read_count_next = '0;
    end else if (ctl.step && sel) begin
      if (ctl.needed && (count != '1)) begin
        count_next = count + COUNT_WIDTH'(1);
      end
      if (read_count != '1) begin
        read_count_next = read_count + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      read_count <= '0;
    end else begin
      count      <= count_next;
      read_count <= read_count_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/peqc_merge.sv
// Merging stages: grouped minimum over the lanes, query select and result register.
// Depends on peqc_pkg.
`default_nettype none

module peqc_merge
  import peqc_pkg::*;
#(
  parameter int NUM_INPUTS  = NUM_INPUTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   adv,
  input  wire pend_t                                  pend,
  input  wire logic                                   started,
  input  wire logic      [COUNT_WIDTH-1:0]            total,
  input  wire logic      [NUM_INPUTS-1:0][COUNT_WIDTH-1:0] counts,
  input  wire logic      [NUM_INPUTS-1:0][COUNT_WIDTH-1:0] read_counts,
  input  wire logic      [NUM_INPUTS-1:0]             use_mask,
  output logic                                        out_valid,
  output out_t                                        out_data
);

  localparam int NumGroups = (NUM_INPUTS + GROUP - 1) / GROUP;
  localparam int PadN      = NumGroups * GROUP;

  logic [PadN-1:0][COUNT_WIDTH-1:0] pad_cnt;
  logic [NumGroups-1:0][COUNT_WIDTH-1:0] gmin_next;
  logic [NumGroups-1:0][COUNT_WIDTH-1:0] gmin;
  logic [COUNT_WIDTH-1:0] qcnt_next;
  logic [COUNT_WIDTH-1:0] qrd_next;
  logic [COUNT_WIDTH-1:0] qcnt;
  logic [COUNT_WIDTH-1:0] qrd;
  logic [COUNT_WIDTH-1:0] total_s1;
  logic [COUNT_WIDTH-1:0] min_all;
  logic                   s1_valid;
  logic                   s1_needed;
  logic                   s1_started;
  logic                   s1_none;

  genvar gi;
  generate
    for (gi = 0; gi < PadN; gi++) begin : g_pad
      if (gi < NUM_INPUTS) begin : g_lane
        assign pad_cnt[gi] = use_mask[gi] ? counts[gi] : '1;
      end else begin : g_fill
        assign pad_cnt[gi] = '1;
      end
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      gmin_next[g] = pad_cnt[g*GROUP];
      for (int k = 1; k < GROUP; k++) begin
        if (pad_cnt[g*GROUP+k] < gmin_next[g]) begin
          gmin_next[g] = pad_cnt[g*GROUP+k];
        end
      end
    end
  end

  always_comb begin
    qcnt_next = '0;
    qrd_next  = '0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if ({1'b0, pend.query} == 5'(i)) begin
        qcnt_next = counts[i];
        qrd_next  = read_counts[i];
      end
    end
  end

  always_comb begin
    min_all = gmin[0];
    for (int g = 1; g < NumGroups; g++) begin
      if (gmin[g] < min_all) begin
        min_all = gmin[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pend.valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gmin       <= gmin_next;
      qcnt       <= qcnt_next;
      qrd        <= qrd_next;
      total_s1   <= total;
      s1_needed  <= pend.needed;
      s1_started <= started;
      s1_none    <= ~|use_mask;

      out_data.is_needed          <= s1_needed;
      out_data.needed_total       <= 32'(total_s1);
      out_data.queried_count      <= 32'(qcnt);
      out_data.queried_read_count <= 32'(qrd);
      out_data.lowest_count       <= s1_started ? 32'(min_all) : 32'd0;
      out_data.all_excluded       <= s1_started & s1_none;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/per_input_event_quota_counter.sv
// Top level of the per-input event quota counter: register port, lanes and merge.
// Depends on peqc_pkg, peqc_lane and peqc_merge.
//
//   Channel  Direction  Handshake               Beat
//   in       sink       in_valid / in_ready     in_t: action, bitmap, query
//   out      source     out_valid / out_ready   out_t: counts and flags
//   apb      slave      psel / penable          registers at 0x0, 0x4, 0x8
//
// One beat is taken every cycle while the output is not stalled; its result passes the pend, s1 and result registers.
// The lanes update their counters at the accepting edge; two merge stages follow.
// A stalled output holds the whole pipeline, and in_ready drops with it.
// Reset clears counters, registers and pipeline valid bits.
`default_nettype none

module per_input_event_quota_counter
  import peqc_pkg::*;
#(
  parameter int NUM_INPUTS  = NUM_INPUTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [31:0]           requested_events;
  logic [15:0]           input_mask;
  logic [15:0]           live_inputs;
  logic                  adv;
  logic                  accept;
  logic                  is_event;
  logic                  is_clear;
  logic                  needed;
  logic                  run_started;
  logic                  run_started_next;
  logic [COUNT_WIDTH-1:0] needed_events;
  logic [COUNT_WIDTH-1:0] needed_events_next;
  logic [NUM_INPUTS-1:0] sel;
  logic [NUM_INPUTS-1:0] below;
  logic [NUM_INPUTS-1:0] use_mask;
  logic [NUM_INPUTS-1:0][COUNT_WIDTH-1:0] counts;
  logic [NUM_INPUTS-1:0][COUNT_WIDTH-1:0] read_counts;
  lane_ctl_t             ctl;
  pend_t                 pend;
  logic [1:0]            reg_sel;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      requested_events <= '0;
      input_mask       <= '0;
      live_inputs      <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_REQUESTED: requested_events <= pwdata;
        REG_MASK:      input_mask       <= pwdata[15:0];
        REG_LIVE:      live_inputs      <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_REQUESTED: prdata = requested_events;
      REG_MASK:      prdata = {16'd0, input_mask};
      REG_LIVE:      prdata = {16'd0, live_inputs};
      default:       prdata = '0;
    endcase
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;
  assign is_event = accept && (in_data.action == ACT_EVENT);
  assign is_clear = accept && (in_data.action == ACT_START || in_data.action == ACT_STOP);

  assign sel      = in_data.nonempty_inputs[NUM_INPUTS-1:0] & ~input_mask[NUM_INPUTS-1:0];
  assign use_mask = live_inputs[NUM_INPUTS-1:0] & ~input_mask[NUM_INPUTS-1:0];
  assign needed   = is_event && (|below);

  assign ctl = '{clear: is_clear, step: is_event, needed: needed};

  genvar li;
  generate
    for (li = 0; li < NUM_INPUTS; li++) begin : g_lane
      peqc_lane #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_lane (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .sel       (sel[li]),
        .quota     (requested_events),
        .count     (counts[li]),
        .read_count(read_counts[li]),
        .below     (below[li])
      );
    end
  endgenerate

  always_comb begin
    needed_events_next = needed_events;
    run_started_next   = run_started;
    if (is_clear) begin
      needed_events_next = '0;
      run_started_next   = (in_data.action == ACT_START);
    end else if (needed && (needed_events != '1)) begin
      needed_events_next = needed_events + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needed_events <= '0;
      run_started   <= 1'b0;
      pend.valid    <= 1'b0;
    end else begin
      needed_events <= needed_events_next;
      run_started   <= run_started_next;
      if (adv) begin
        pend.valid <= in_valid;
      end
    end
    if (adv) begin
      pend.needed <= needed;
      pend.query  <= in_data.query_index;
    end
  end

  peqc_merge #(
    .NUM_INPUTS (NUM_INPUTS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .pend       (pend),
    .started    (run_started),
    .total      (needed_events),
    .counts     (counts),
    .read_counts(read_counts),
    .use_mask   (use_mask),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
